// ===== hdl/kmmeg_pkg.sv =====
// package for the key matrix event generator
// shared widths, reset values, event kind codes and controller/datapath structs
// no dependencies
package kmmeg_pkg;

  localparam int ROW_COUNT_DEF = 4;
  localparam int COL_COUNT_DEF = 8;
  localparam int LEVEL_W       = 8;
  localparam int ROW_W_IN      = 2;
  localparam int POT_W         = 12;

  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int CHAN_W = 5;
  localparam int KIND_W = 2;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [NOTE_W-1:0] ROOT_NOTE_RST = 7'd48;
  localparam logic [VEL_W-1:0]  VELOCITY_RST  = 7'd100;
  localparam logic [CHAN_W-1:0] CHANNEL_RST   = 5'd1;
  localparam logic [NOTE_W-1:0] CC_NUMBER_RST = 7'd1;
  localparam logic [VEL_W-1:0]  CC_MAX        = 7'd127;

  localparam logic [1:0] REG_ROOT_NOTE = 2'd0;
  localparam logic [1:0] REG_VELOCITY  = 2'd1;
  localparam logic [1:0] REG_CHANNEL   = 2'd2;
  localparam logic [1:0] REG_CC_NUMBER = 2'd3;

  localparam logic CMD_ROW = 1'b0;
  localparam logic CMD_POT = 1'b1;

  localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CC       = 2'd2;

  typedef struct packed {
    logic [NOTE_W-1:0] root_note;
    logic [VEL_W-1:0]  note_velocity;
    logic [CHAN_W-1:0] midi_channel;
    logic [NOTE_W-1:0] cc_number;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic col_step;
    logic emit_note;
    logic emit_cc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic row_ok;
    logic diff_any;
    logic cc_fire;
    logic cur_diff;
    logic rest_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/kmmeg_cfg.sv =====
// configuration registers behind an apb-style port
// depends on kmmeg_pkg
module kmmeg_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kmmeg_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [kmmeg_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [kmmeg_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  output kmmeg_pkg::cfg_t                     cfg_o
);

  kmmeg_pkg::cfg_t cfg_q;
  logic [1:0]      reg_idx;
  logic            wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.root_note     <= kmmeg_pkg::ROOT_NOTE_RST;
      cfg_q.note_velocity <= kmmeg_pkg::VELOCITY_RST;
      cfg_q.midi_channel  <= kmmeg_pkg::CHANNEL_RST;
      cfg_q.cc_number     <= kmmeg_pkg::CC_NUMBER_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        kmmeg_pkg::REG_ROOT_NOTE: cfg_q.root_note     <= pwdata[kmmeg_pkg::NOTE_W-1:0];
        kmmeg_pkg::REG_VELOCITY:  cfg_q.note_velocity <= pwdata[kmmeg_pkg::VEL_W-1:0];
        kmmeg_pkg::REG_CHANNEL:   cfg_q.midi_channel  <= pwdata[kmmeg_pkg::CHAN_W-1:0];
        kmmeg_pkg::REG_CC_NUMBER: cfg_q.cc_number     <= pwdata[kmmeg_pkg::NOTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      kmmeg_pkg::REG_ROOT_NOTE: prdata = kmmeg_pkg::APB_DATA_W'(cfg_q.root_note);
      kmmeg_pkg::REG_VELOCITY:  prdata = kmmeg_pkg::APB_DATA_W'(cfg_q.note_velocity);
      kmmeg_pkg::REG_CHANNEL:   prdata = kmmeg_pkg::APB_DATA_W'(cfg_q.midi_channel);
      kmmeg_pkg::REG_CC_NUMBER: prdata = kmmeg_pkg::APB_DATA_W'(cfg_q.cc_number);
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== hdl/kmmeg_ctrl.sv =====
// controller state machine: accepts a transaction, walks the columns, emits events
// depends on kmmeg_pkg
module kmmeg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  cmd_i,
  output logic                  in_stall_o,
  input  kmmeg_pkg::dp_status_t status_i,
  output kmmeg_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CC   = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (cmd_i == kmmeg_pkg::CMD_POT) begin
            if (status_i.cc_fire) state_d = ST_CC;
          end else if (status_i.row_ok && status_i.diff_any) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // a changed column waits for the output register to free up
        if (!status_i.cur_diff || status_i.out_free) begin
          cmd_o.emit_note = status_i.cur_diff;
          cmd_o.col_step  = 1'b1;
          if (status_i.rest_zero) state_d = ST_IDLE;
        end
      end
      ST_CC: begin
        if (status_i.out_free) begin
          cmd_o.emit_cc = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/kmmeg_dp.sv =====
// datapath: key state, change mask, column counter, control change state, output register
// depends on kmmeg_pkg
module kmmeg_dp #(
  parameter int ROW_COUNT = kmmeg_pkg::ROW_COUNT_DEF,
  parameter int COL_COUNT = kmmeg_pkg::COL_COUNT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  kmmeg_pkg::cfg_t                       cfg_i,
  input  kmmeg_pkg::ctrl_cmd_t                  cmd_i,
  output kmmeg_pkg::dp_status_t                 status_o,
  input  logic                                  cmd_bit_i,
  input  logic [kmmeg_pkg::ROW_W_IN-1:0]        row_i,
  input  logic [kmmeg_pkg::LEVEL_W-1:0]         col_levels_i,
  input  logic [kmmeg_pkg::POT_W-1:0]           pot_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [kmmeg_pkg::KIND_W-1:0]          kind_o,
  output logic [kmmeg_pkg::CHAN_W-1:0]          channel_o,
  output logic [kmmeg_pkg::NOTE_W-1:0]          number_o,
  output logic [kmmeg_pkg::VEL_W-1:0]           value_o,
  output logic                                  last_o
);

  localparam int SCAN_COLS = (COL_COUNT < kmmeg_pkg::LEVEL_W) ? COL_COUNT : kmmeg_pkg::LEVEL_W;
  localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int COL_W     = (SCAN_COLS > 1) ? $clog2(SCAN_COLS) : 1;

  logic [SCAN_COLS-1:0]          keys_q [ROW_COUNT];
  logic [SCAN_COLS-1:0]          diff_q, diff_d, on_q, pressed, col_bit;
  logic [COL_W-1:0]              col_q;
  logic [kmmeg_pkg::NOTE_W-1:0]  note_base_q, note_base_d, note;
  logic [31:0]                   row_ext, col_ext;
  logic [ROW_W-1:0]              row_idx;
  logic                          row_write;

  logic [kmmeg_pkg::VEL_W-1:0]   last_cc_q, cc_val_q, cc_new;
  logic                          cc_sent_q;
  logic [kmmeg_pkg::POT_W-4:0]   pot_div;

  logic                          out_valid_q;
  logic [kmmeg_pkg::KIND_W-1:0]  kind_q;
  logic [kmmeg_pkg::CHAN_W-1:0]  channel_q;
  logic [kmmeg_pkg::NOTE_W-1:0]  number_q;
  logic [kmmeg_pkg::VEL_W-1:0]   value_q;
  logic                          last_q;

  // row sample decode
  assign row_ext     = 32'(row_i);
  assign row_idx     = row_ext[ROW_W-1:0];
  assign pressed     = ~col_levels_i[SCAN_COLS-1:0];
  assign note_base_d = cfg_i.root_note + kmmeg_pkg::NOTE_W'(row_ext * COL_COUNT);
  assign row_write   = cmd_i.capture && (cmd_bit_i == kmmeg_pkg::CMD_ROW) && status_o.row_ok;

  // pot sample: divide by 8, clamp
  assign pot_div = pot_sample_i[kmmeg_pkg::POT_W-1:3];
  assign cc_new  = (pot_div > 9'(kmmeg_pkg::CC_MAX)) ? kmmeg_pkg::CC_MAX
                                                      : pot_div[kmmeg_pkg::VEL_W-1:0];

  // column walk
  assign col_bit = SCAN_COLS'(1) << col_q;
  assign diff_d  = diff_q & ~col_bit;
  assign col_ext = 32'(col_q);
  assign note    = note_base_q + col_ext[kmmeg_pkg::NOTE_W-1:0];

  assign status_o.row_ok    = (row_ext < ROW_COUNT);
  assign status_o.diff_any  = |(pressed ^ keys_q[row_idx]);
  assign status_o.cc_fire   = !cc_sent_q || (cc_new != last_cc_q);
  assign status_o.cur_diff  = |(diff_q & col_bit);
  assign status_o.rest_zero = (diff_d == '0);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        keys_q[r] <= '0;
      end
      last_cc_q <= '0;
      cc_sent_q <= 1'b0;
    end else begin
      // the row's final state is known at once; the change mask drives the events
      if (row_write) keys_q[row_idx] <= pressed;
      if (cmd_i.capture && (cmd_bit_i == kmmeg_pkg::CMD_POT) && status_o.cc_fire) begin
        last_cc_q <= cc_new;
        cc_sent_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      diff_q      <= pressed ^ keys_q[row_idx];
      on_q        <= pressed;
      note_base_q <= note_base_d;
      col_q       <= '0;
      cc_val_q    <= cc_new;
    end else if (cmd_i.col_step) begin
      diff_q <= diff_d;
      col_q  <= col_q + COL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_note || cmd_i.emit_cc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_note) begin
      kind_q    <= (|(on_q & col_bit)) ? kmmeg_pkg::KIND_NOTE_ON : kmmeg_pkg::KIND_NOTE_OFF;
      value_q   <= (|(on_q & col_bit)) ? cfg_i.note_velocity : '0;
      number_q  <= note;
      channel_q <= cfg_i.midi_channel;
      last_q    <= status_o.rest_zero;
    end else if (cmd_i.emit_cc) begin
      kind_q    <= kmmeg_pkg::KIND_CC;
      value_q   <= cc_val_q;
      number_q  <= cfg_i.cc_number;
      channel_q <= cfg_i.midi_channel;
      last_q    <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign channel_o   = channel_q;
  assign number_o    = number_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

  a_emit_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit_note && cmd_i.emit_cc))
    else $error("note and control change emitted together");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_note || cmd_i.emit_cc) |-> status_o.out_free)
    else $error("output register overwritten while held");

  a_note_on_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_note |-> status_o.cur_diff)
    else $error("note event for an unchanged column");

  a_step_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.col_step && !cmd_i.capture) |=> ((diff_q & $past(col_bit)) == '0))
    else $error("change bit survived its column step");

endmodule

// ===== hdl/key_matrix_midi_event_generator_top.sv =====
// row sample: accepted when idle, then one column a cycle up to the highest changed column;
//   a changed column waits while the output register is held by a stall
// pot sample: accepted when idle; a new control change loads the output register once it is free
// events reach the output register from the scan or control change state; one sample at a time
// reset clears key state, control change history and output valid, and loads register defaults
// depends on kmmeg_pkg, kmmeg_cfg, kmmeg_ctrl and kmmeg_dp
module key_matrix_midi_event_generator_top #(
  parameter int ROW_COUNT = kmmeg_pkg::ROW_COUNT_DEF,
  parameter int COL_COUNT = kmmeg_pkg::COL_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [kmmeg_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [kmmeg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [kmmeg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [kmmeg_pkg::ROW_W_IN-1:0]     row_i,
  input  logic [kmmeg_pkg::LEVEL_W-1:0]      col_levels_i,
  input  logic [kmmeg_pkg::POT_W-1:0]        pot_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [kmmeg_pkg::KIND_W-1:0]       kind_o,
  output logic [kmmeg_pkg::CHAN_W-1:0]       channel_o,
  output logic [kmmeg_pkg::NOTE_W-1:0]       number_o,
  output logic [kmmeg_pkg::VEL_W-1:0]        value_o,
  output logic                               last_o
);

  kmmeg_pkg::cfg_t       cfg;
  kmmeg_pkg::ctrl_cmd_t  ctrl_cmd;
  kmmeg_pkg::dp_status_t dp_status;

  kmmeg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kmmeg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  kmmeg_dp #(
    .ROW_COUNT (ROW_COUNT),
    .COL_COUNT (COL_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (ctrl_cmd),
    .status_o     (dp_status),
    .cmd_bit_i    (cmd_i),
    .row_i        (row_i),
    .col_levels_i (col_levels_i),
    .pot_sample_i (pot_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .channel_o    (channel_o),
    .number_o     (number_o),
    .value_o      (value_o),
    .last_o       (last_o)
  );

endmodule

// ===== bench/key_matrix_event_checker.sv =====
// checker for the key matrix event generator: watches the register port and both channels,
// keeps its own copy of key state and registers, and compares every event that leaves the block
// depends on kmmeg_pkg
module key_matrix_event_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic                             pready_i,
  input  logic [kmmeg_pkg::APB_ADDR_W-1:0] paddr_i,
  input  logic [kmmeg_pkg::APB_DATA_W-1:0] pwdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic                             cmd_i,
  input  logic [kmmeg_pkg::ROW_W_IN-1:0]   row_i,
  input  logic [kmmeg_pkg::LEVEL_W-1:0]    col_levels_i,
  input  logic [kmmeg_pkg::POT_W-1:0]      pot_sample_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [kmmeg_pkg::KIND_W-1:0]     kind_i,
  input  logic [kmmeg_pkg::CHAN_W-1:0]     channel_i,
  input  logic [kmmeg_pkg::NOTE_W-1:0]     number_i,
  input  logic [kmmeg_pkg::VEL_W-1:0]      value_i,
  input  logic                             last_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [kmmeg_pkg::KIND_W-1:0] kind;
    logic [kmmeg_pkg::CHAN_W-1:0] channel;
    logic [kmmeg_pkg::NOTE_W-1:0] number;
    logic [kmmeg_pkg::VEL_W-1:0]  value;
    logic                         last;
  } midi_event_t;

  kmmeg_pkg::cfg_t               shadow_cfg;
  logic [kmmeg_pkg::LEVEL_W-1:0] held_keys [kmmeg_pkg::ROW_COUNT_DEF];
  logic [kmmeg_pkg::VEL_W-1:0]   cc_last_value;
  logic                          cc_history;
  midi_event_t                   expected_events [$];

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t ns: event mismatch on %s, got %0d, want %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // works out the events one accepted sample causes and queues them in order
  task automatic derive_events(input logic kind_bit, input logic [kmmeg_pkg::ROW_W_IN-1:0] row,
                               input logic [kmmeg_pkg::LEVEL_W-1:0] levels,
                               input logic [kmmeg_pkg::POT_W-1:0] pot);
    logic [kmmeg_pkg::LEVEL_W-1:0] now_pressed;
    logic [kmmeg_pkg::LEVEL_W-1:0] changed;
    logic [kmmeg_pkg::POT_W-4:0]   scaled;
    logic [kmmeg_pkg::VEL_W-1:0]   cc_value;
    midi_event_t                   ev;
    if (kind_bit == kmmeg_pkg::CMD_ROW) begin
      if (int'(row) >= kmmeg_pkg::ROW_COUNT_DEF) return;
      now_pressed = ~levels;
      changed     = now_pressed ^ held_keys[row];
      for (int c = 0; c < kmmeg_pkg::LEVEL_W && c < kmmeg_pkg::COL_COUNT_DEF; c++) begin
        if (changed[c]) begin
          ev.kind    = now_pressed[c] ? kmmeg_pkg::KIND_NOTE_ON : kmmeg_pkg::KIND_NOTE_OFF;
          ev.channel = shadow_cfg.midi_channel;
          // note number wraps at 7 bits
          ev.number  = shadow_cfg.root_note
                     + kmmeg_pkg::NOTE_W'(int'(row) * kmmeg_pkg::COL_COUNT_DEF + c);
          ev.value   = now_pressed[c] ? shadow_cfg.note_velocity : '0;
          ev.last    = ((changed >> (c + 1)) == '0);
          expected_events.push_back(ev);
        end
      end
      held_keys[row] = now_pressed;
    end else begin
      scaled   = pot[kmmeg_pkg::POT_W-1:3];
      cc_value = (scaled > kmmeg_pkg::CC_MAX) ? kmmeg_pkg::CC_MAX
                                              : scaled[kmmeg_pkg::VEL_W-1:0];
      if (!cc_history || cc_value != cc_last_value) begin
        ev.kind    = kmmeg_pkg::KIND_CC;
        ev.channel = shadow_cfg.midi_channel;
        ev.number  = shadow_cfg.cc_number;
        ev.value   = cc_value;
        ev.last    = 1'b1;
        expected_events.push_back(ev);
        cc_last_value = cc_value;
        cc_history    = 1'b1;
      end
    end
  endtask

  task automatic compare_event();
    midi_event_t want;
    if (expected_events.size() == 0) begin
      flag_mismatch("event with nothing outstanding, kind", kind_i, -1);
      return;
    end
    want = expected_events.pop_front();
    if (kind_i != want.kind)       flag_mismatch("kind", kind_i, want.kind);
    if (channel_i != want.channel) flag_mismatch("channel", channel_i, want.channel);
    if (number_i != want.number)   flag_mismatch("number", number_i, want.number);
    if (value_i != want.value)     flag_mismatch("value", value_i, want.value);
    if (last_i != want.last)       flag_mismatch("last", last_i, want.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_events.delete();
      for (int r = 0; r < kmmeg_pkg::ROW_COUNT_DEF; r++) held_keys[r] = '0;
      fail_count_o             = 0;
      cc_last_value            = '0;
      cc_history               = 1'b0;
      shadow_cfg.root_note     = kmmeg_pkg::ROOT_NOTE_RST;
      shadow_cfg.note_velocity = kmmeg_pkg::VELOCITY_RST;
      shadow_cfg.midi_channel  = kmmeg_pkg::CHANNEL_RST;
      shadow_cfg.cc_number     = kmmeg_pkg::CC_NUMBER_RST;
    end else begin
      // retire the outgoing transaction first, a new sample only queues behind it
      if (out_valid_i && !out_stall_i) compare_event();
      if (in_valid_i && !in_stall_i) derive_events(cmd_i, row_i, col_levels_i, pot_sample_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          kmmeg_pkg::REG_ROOT_NOTE: shadow_cfg.root_note     = pwdata_i[kmmeg_pkg::NOTE_W-1:0];
          kmmeg_pkg::REG_VELOCITY:  shadow_cfg.note_velocity = pwdata_i[kmmeg_pkg::VEL_W-1:0];
          kmmeg_pkg::REG_CHANNEL:   shadow_cfg.midi_channel  = pwdata_i[kmmeg_pkg::CHAN_W-1:0];
          kmmeg_pkg::REG_CC_NUMBER: shadow_cfg.cc_number     = pwdata_i[kmmeg_pkg::NOTE_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_events.size();
  end

endmodule

// ===== bench/tb_key_matrix_midi_event_generator_top.sv =====
// testbench top for the key matrix event generator: clock, reset, register writes,
// row and pot samples with random idling and output stalls, and the verdict
// depends on kmmeg_pkg, key_matrix_midi_event_generator_top and key_matrix_event_checker
module tb_key_matrix_midi_event_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                             clk;
  logic                             rst_n;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [kmmeg_pkg::APB_ADDR_W-1:0] paddr;
  logic [kmmeg_pkg::APB_DATA_W-1:0] pwdata;
  logic [kmmeg_pkg::APB_DATA_W-1:0] prdata;
  logic                             pready;
  logic                             in_valid;
  logic                             in_stall;
  logic                             cmd;
  logic [kmmeg_pkg::ROW_W_IN-1:0]   row;
  logic [kmmeg_pkg::LEVEL_W-1:0]    col_levels;
  logic [kmmeg_pkg::POT_W-1:0]      pot_sample;
  logic                             out_valid;
  logic                             out_stall;
  logic [kmmeg_pkg::KIND_W-1:0]     kind;
  logic [kmmeg_pkg::CHAN_W-1:0]     channel;
  logic [kmmeg_pkg::NOTE_W-1:0]     number;
  logic [kmmeg_pkg::VEL_W-1:0]      value;
  logic                             last;

  int fail_count;
  int pending;
  int gap_pct;
  int stall_pct;

  // last levels sent per row, so that random samples can press or release single keys
  logic [kmmeg_pkg::LEVEL_W-1:0] sent_levels [kmmeg_pkg::ROW_COUNT_DEF];
  logic [kmmeg_pkg::POT_W-1:0]   sent_pot;

  key_matrix_midi_event_generator_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cmd_i       (cmd),
    .row_i       (row),
    .col_levels_i(col_levels),
    .pot_sample_i(pot_sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .channel_o   (channel),
    .number_o    (number),
    .value_o     (value),
    .last_o      (last)
  );

  key_matrix_event_checker event_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .cmd_i       (cmd),
    .row_i       (row),
    .col_levels_i(col_levels),
    .pot_sample_i(pot_sample),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .kind_i      (kind),
    .channel_i   (channel),
    .number_i    (number),
    .value_i     (value),
    .last_i      (last),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [kmmeg_pkg::APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // returns at the rising edge where the transaction is taken
  task automatic send_item(input logic c, input logic [kmmeg_pkg::ROW_W_IN-1:0] r,
                           input logic [kmmeg_pkg::LEVEL_W-1:0] lv,
                           input logic [kmmeg_pkg::POT_W-1:0] pt);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    cmd        = c;
    row        = r;
    col_levels = lv;
    pot_sample = pt;
    if (c == kmmeg_pkg::CMD_ROW) sent_levels[r] = lv;
    else sent_pot = pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // let every queued event leave before touching registers, since the block reads most of them as it emits
  task automatic apply_setting(input logic [kmmeg_pkg::APB_DATA_W-1:0] base,
                               input logic [kmmeg_pkg::APB_DATA_W-1:0] vel,
                               input logic [kmmeg_pkg::APB_DATA_W-1:0] chan,
                               input logic [kmmeg_pkg::APB_DATA_W-1:0] ccn);
    wait_drained();
    repeat (16) @(negedge clk);
    write_reg(kmmeg_pkg::REG_ROOT_NOTE, base);
    write_reg(kmmeg_pkg::REG_VELOCITY, vel);
    write_reg(kmmeg_pkg::REG_CHANNEL, chan);
    write_reg(kmmeg_pkg::REG_CC_NUMBER, ccn);
  endtask

  task automatic run_random(input int count);
    int                             pick;
    logic [kmmeg_pkg::ROW_W_IN-1:0] r;
    logic [kmmeg_pkg::LEVEL_W-1:0]  lv;
    logic [kmmeg_pkg::POT_W-1:0]    pt;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 || $urandom_range(24) == 0) wait_drained();
      r  = kmmeg_pkg::ROW_W_IN'($urandom_range(kmmeg_pkg::ROW_COUNT_DEF - 1));
      lv = kmmeg_pkg::LEVEL_W'($urandom);
      pt = kmmeg_pkg::POT_W'($urandom);
      if ($urandom_range(99) < 65) begin
        pick = $urandom_range(99);
        if (pick < 40)
          lv = sent_levels[r]
             ^ kmmeg_pkg::LEVEL_W'(1 << $urandom_range(kmmeg_pkg::LEVEL_W - 1));
        else if (pick < 55) lv = sent_levels[r];
        else if (pick < 65) lv = '0;
        else if (pick < 75) lv = '1;
        send_item(kmmeg_pkg::CMD_ROW, r, lv, pt);
      end else begin
        pick = $urandom_range(99);
        if (pick < 25)      pt = sent_pot;
        else if (pick < 50) pt = kmmeg_pkg::POT_W'($urandom_range(4095, 1016));
        else if (pick < 75) pt = sent_pot + kmmeg_pkg::POT_W'($urandom_range(15));
        send_item(kmmeg_pkg::CMD_POT, r, lv, pt);
      end
    end
  endtask

  initial begin
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    cmd        = kmmeg_pkg::CMD_ROW;
    row        = '0;
    col_levels = '1;
    pot_sample = '0;
    gap_pct    = 0;
    stall_pct  = 0;
    sent_pot   = '0;
    for (int r = 0; r < kmmeg_pkg::ROW_COUNT_DEF; r++) sent_levels[r] = '1;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part under the reset register values
    send_item(kmmeg_pkg::CMD_ROW, 2'd0, 8'h00, 12'hFFF);  // whole row pressed, pot field ignored
    send_item(kmmeg_pkg::CMD_ROW, 2'd0, 8'hFF, 12'h000);
    send_item(kmmeg_pkg::CMD_ROW, 2'd3, 8'h7E, 12'hABC);  // outer columns of the top row
    send_item(kmmeg_pkg::CMD_ROW, 2'd3, 8'h7E, 12'h000);  // unchanged, no events
    send_item(kmmeg_pkg::CMD_ROW, 2'd3, 8'hFF, 12'h000);
    send_item(kmmeg_pkg::CMD_ROW, 2'd1, 8'hAA, 12'h000);
    send_item(kmmeg_pkg::CMD_ROW, 2'd2, 8'h55, 12'h000);
    send_item(kmmeg_pkg::CMD_ROW, 2'd1, 8'h55, 12'h000);  // every column flips
    send_item(kmmeg_pkg::CMD_ROW, 2'd2, 8'hFF, 12'h000);
    send_item(kmmeg_pkg::CMD_ROW, 2'd1, 8'hFF, 12'h000);
    send_item(kmmeg_pkg::CMD_POT, 2'd3, 8'h00, 12'd0);    // first control change, even for zero
    send_item(kmmeg_pkg::CMD_POT, 2'd0, 8'hFF, 12'd7);    // same value, nothing sent
    send_item(kmmeg_pkg::CMD_POT, 2'd0, 8'h00, 12'd8);
    send_item(kmmeg_pkg::CMD_POT, 2'd2, 8'h5A, 12'd1023);
    send_item(kmmeg_pkg::CMD_POT, 2'd1, 8'hA5, 12'd1024); // clamps to the value already sent
    send_item(kmmeg_pkg::CMD_POT, 2'd0, 8'h00, 12'd4095);
    send_item(kmmeg_pkg::CMD_POT, 2'd0, 8'h00, 12'd0);
    send_item(kmmeg_pkg::CMD_POT, 2'd0, 8'h00, 12'd4095);
    send_item(kmmeg_pkg::CMD_ROW, 2'd2, 8'hFE, 12'hFFF);
    send_item(kmmeg_pkg::CMD_ROW, 2'd2, 8'h7F, 12'h555);
    send_item(kmmeg_pkg::CMD_ROW, 2'd2, 8'hFF, 12'hAAA);

    // root note and control change number at zero, velocity one, channel 16, no idling
    apply_setting(32'd0, 32'd1, 32'd16, 32'd0);
    run_random(40);

    // highest values, notes wrap past 127 and channel beyond 16
    apply_setting(32'd127, 32'd127, 32'd31, 32'd127);
    gap_pct = 53;
    run_random(40);

    // zero velocity and channel zero
    apply_setting(32'd96, 32'd0, 32'd0, 32'd64);
    gap_pct   = 0;
    stall_pct = 53;
    run_random(40);

    // random registers with junk in the upper data bits
    apply_setting($urandom, $urandom, $urandom, $urandom);
    gap_pct   = 38;
    stall_pct = 38;
    run_random(40);

    wait_drained();
    repeat (16) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
